// ===== hw/rtl/imu_report_sample_sequencer_core_assert.svh =====
// Assertion macros for the inertial report sequencer port checker.
`ifndef IMU_REPORT_SAMPLE_SEQUENCER_CORE_ASSERT_SVH
`define IMU_REPORT_SAMPLE_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IRSS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IRSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/irss_pkg.sv =====
// Shared types, constants and helpers for the inertial report sequencer.
package irss_pkg;

  localparam int REPORT_BYTES = 52;
  localparam int COUNT_CAP    = 53;
  localparam int SAMPLE_BYTES = 17;
  localparam int SAMPLE_COUNT = 3;
  localparam int CNT_W        = 6;
  localparam int WALK_W       = 2;
  localparam int STATUS_W     = 2;
  localparam int SAMPLE_W     = SAMPLE_BYTES * 8;
  localparam int TICKS_W      = 32;
  localparam int OUT_W        = SAMPLE_W + TICKS_W;
  localparam int TICKS_LSB    = 96;
  localparam int DELTA_LSB    = SAMPLE_W;

  localparam logic [TICKS_W-1:0] TICKS_ALL   = 32'hFFFF_FFFF;
  localparam logic [TICKS_W-1:0] WRAP_WINDOW = TICKS_ALL >> 2;

  localparam logic [STATUS_W-1:0] STATUS_SAMPLE     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_LENGTH = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_UNKNOWN_ID = 2'd2;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [OUT_W-1:0]    result_t;

  typedef struct packed {
    logic                        load_walk;
    logic                        load_err;
    logic [STATUS_W-1:0]         code;
    sample_t [SAMPLE_COUNT-1:0]  slots;
  } job_t;

  // Wrap-aware "t is newer than s".
  function automatic logic irss_newer(input logic [TICKS_W-1:0] t,
                                      input logic [TICKS_W-1:0] s);
    logic [TICKS_W:0] diff;
    logic             res;
    diff = {1'b0, t} - {1'b0, s};
    if (diff[TICKS_W-1:0] == '0) begin
      res = 1'b0;
    end else if (diff[TICKS_W]) begin
      res = (diff[TICKS_W-1:0] <= ~WRAP_WINDOW);
    end else begin
      res = (diff[TICKS_W-1:0] < WRAP_WINDOW);
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/irss_capture.sv =====
// Report byte store, length count and end-of-report decode into a walk or error job.
module irss_capture
  import irss_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       beat,
  input  logic [7:0] data_byte,
  input  logic       end_flag,
  input  logic [7:0] report_id,
  output job_t       job
);

  logic [7:0]       store_r [REPORT_BYTES];
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [7:0]       cur_b [REPORT_BYTES];
  sample_t          smp [SAMPLE_COUNT];
  logic [7:0]       seq0;
  logic [7:0]       seq1;
  logic [7:0]       seq2;
  logic             id_ok;
  logic             len_ok;

  always_ff @(posedge clk) begin
    if (beat && (cnt_r < CNT_W'(REPORT_BYTES))) begin
      store_r[cnt_r] <= data_byte;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (beat) begin
      if (end_flag) begin
        cnt_nxt = '0;
      end else if (cnt_r < CNT_W'(COUNT_CAP)) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Merge the current beat into the stored view.
  always_comb begin
    for (int i = 0; i < REPORT_BYTES; i++) begin
      cur_b[i] = (cnt_r == CNT_W'(i)) ? data_byte : store_r[i];
    end
    for (int s = 0; s < SAMPLE_COUNT; s++) begin
      for (int j = 0; j < SAMPLE_BYTES; j++) begin
        smp[s][8*j +: 8] = cur_b[1 + s*SAMPLE_BYTES + j];
      end
    end
  end

  assign seq0   = smp[0][SAMPLE_W-1 -: 8];
  assign seq1   = smp[1][SAMPLE_W-1 -: 8];
  assign seq2   = smp[2][SAMPLE_W-1 -: 8];
  assign id_ok  = (cur_b[0] == report_id);
  assign len_ok = (cnt_r == CNT_W'(REPORT_BYTES - 1));

  always_comb begin
    job.load_walk = 1'b0;
    job.load_err  = 1'b0;
    job.code      = STATUS_SAMPLE;
    // Order the slots oldest first.
    if (seq0 == seq1 + 8'd2) begin
      job.slots = {smp[0], smp[2], smp[1]};
    end else if (seq1 == seq2 + 8'd2) begin
      job.slots = {smp[1], smp[0], smp[2]};
    end else begin
      job.slots = {smp[2], smp[1], smp[0]};
    end
    if (beat && end_flag) begin
      if (!id_ok) begin
        job.load_err = 1'b1;
        job.code     = STATUS_UNKNOWN_ID;
      end else if (!len_ok) begin
        job.load_err = 1'b1;
        job.code     = STATUS_BAD_LENGTH;
      end else begin
        job.load_walk = 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/imu_report_sample_sequencer_core.sv =====
// Top level of the inertial report sequencer: byte input, sample walk, result output.
//
// Input: one report byte per beat on in_tdata, in_tlast on the report's final byte.
// Config: cfg_tdata is the expected report id, written at a cfg beat; the user
// must write it only while idle, the block does not enforce this. Output: one beat
// per result; out_tuser is the status, out_tlast marks the last result of a report.
// Error results carry all-zero data. A byte is taken every cycle, except a final
// byte while busy. On the final byte of a good report the three samples are latched
// oldest first and walked one per cycle while the output is free, against the
// stored stamp; a kept sample is held until the next kept sample or the walk's end
// so its last flag is known, then sent. An error result passes through the pending
// error register to the output register. Bytes of the next report are taken during
// the walk; only its final byte waits while a walk, held sample or error is still
// pending. A stalled receiver holds the output register and freezes the walk.
// Reset clears the byte count, the stored stamp (unprimed) and sets the id to 32.
module imu_report_sample_sequencer_core
  import irss_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,   // data_byte
  input  logic                in_tlast,
  input  logic                cfg_tvalid,
  output logic                cfg_tready,
  input  logic [7:0]          cfg_tdata,  // sensor_report_id
  output logic                out_tvalid,
  input  logic                out_tready,
  // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, sample_ticks, sample_seq, delta_ticks
  output logic [OUT_W-1:0]    out_tdata,
  output logic [STATUS_W-1:0] out_tuser,  // status
  output logic                out_tlast
);

  job_t                       job;
  logic                       in_beat;
  logic                       busy;
  logic                       out_free;

  logic [7:0]                 id_r, id_nxt;
  logic [TICKS_W-1:0]         last_ticks_r, last_ticks_nxt;
  logic [WALK_W-1:0]          walk_cnt_r, walk_cnt_nxt;
  logic                       err_pend_r, err_pend_nxt;
  logic [STATUS_W-1:0]        err_code_r, err_code_nxt;
  sample_t [SAMPLE_COUNT-1:0] slots_r, slots_nxt;
  logic                       hold_valid_r, hold_valid_nxt;
  result_t                    hold_data_r, hold_data_nxt;
  logic                       out_tvalid_r, out_tvalid_nxt;
  result_t                    out_tdata_r, out_tdata_nxt;
  logic [STATUS_W-1:0]        out_tuser_r, out_tuser_nxt;
  logic                       out_tlast_r, out_tlast_nxt;

  sample_t                    cur;
  logic [TICKS_W-1:0]         cur_ticks;
  logic [TICKS_W-1:0]         delta;
  logic                       newer;

  assign busy       = err_pend_r | (walk_cnt_r != '0) | hold_valid_r;
  assign in_tready  = !(busy && in_tlast);
  assign in_beat    = in_tvalid && in_tready;
  assign cfg_tready = 1'b1;
  assign out_free   = !out_tvalid_r || out_tready;

  irss_capture u_capture (
    .clk       (clk),
    .rst_n     (rst_n),
    .beat      (in_beat),
    .data_byte (in_tdata),
    .end_flag  (in_tlast),
    .report_id (id_r),
    .job       (job)
  );

  assign cur       = slots_r[0];
  assign cur_ticks = cur[TICKS_LSB +: TICKS_W];
  assign delta     = cur_ticks - last_ticks_r;
  assign newer     = irss_newer(cur_ticks, last_ticks_r);

  always_comb begin
    id_nxt         = id_r;
    last_ticks_nxt = last_ticks_r;
    walk_cnt_nxt   = walk_cnt_r;
    err_pend_nxt   = err_pend_r;
    err_code_nxt   = err_code_r;
    slots_nxt      = slots_r;
    hold_valid_nxt = hold_valid_r;
    hold_data_nxt  = hold_data_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    out_tlast_nxt  = out_tlast_r;

    if (cfg_tvalid) begin
      id_nxt = cfg_tdata;
    end

    if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    if (err_pend_r && out_free) begin
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = '0;
      out_tuser_nxt  = err_code_r;
      out_tlast_nxt  = 1'b1;
      err_pend_nxt   = 1'b0;
    end else if ((walk_cnt_r != '0) && out_free) begin
      walk_cnt_nxt = walk_cnt_r - WALK_W'(1);
      slots_nxt[0] = slots_r[1];
      slots_nxt[1] = slots_r[2];
      if (last_ticks_r == '0) begin
        last_ticks_nxt = cur_ticks;
      end else if (newer) begin
        last_ticks_nxt = cur_ticks;
        hold_valid_nxt = 1'b1;
        hold_data_nxt  = {delta, cur};
        if (hold_valid_r) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = hold_data_r;
          out_tuser_nxt  = STATUS_SAMPLE;
          out_tlast_nxt  = 1'b0;
        end
      end
    end else if (hold_valid_r && (walk_cnt_r == '0) && out_free) begin
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = hold_data_r;
      out_tuser_nxt  = STATUS_SAMPLE;
      out_tlast_nxt  = 1'b1;
      hold_valid_nxt = 1'b0;
    end

    if (job.load_walk) begin
      walk_cnt_nxt = WALK_W'(SAMPLE_COUNT);
      slots_nxt    = job.slots;
    end
    if (job.load_err) begin
      err_pend_nxt = 1'b1;
      err_code_nxt = job.code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_r         <= 8'd32;
      last_ticks_r <= '0;
      walk_cnt_r   <= '0;
      err_pend_r   <= 1'b0;
      hold_valid_r <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      id_r         <= id_nxt;
      last_ticks_r <= last_ticks_nxt;
      walk_cnt_r   <= walk_cnt_nxt;
      err_pend_r   <= err_pend_nxt;
      hold_valid_r <= hold_valid_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    err_code_r  <= err_code_nxt;
    slots_r     <= slots_nxt;
    hold_data_r <= hold_data_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
    out_tlast_r <= out_tlast_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

endmodule

// ===== hw/rtl/irss_checker.sv =====
// Port-level checker for the inertial report sequencer, with its bind.
`include "imu_report_sample_sequencer_core_assert.svh"

module irss_checker
  import irss_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_tvalid,
  input logic                in_tready,
  input logic [7:0]          in_tdata,
  input logic                in_tlast,
  input logic                cfg_tvalid,
  input logic                cfg_tready,
  input logic [7:0]          cfg_tdata,
  input logic                out_tvalid,
  input logic                out_tready,
  input logic [OUT_W-1:0]    out_tdata,
  input logic [STATUS_W-1:0] out_tuser,
  input logic                out_tlast
);

  `IRSS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast),
    "stalled result changed")

  `IRSS_ASSERT_NOW(a_err_shape, clk, rst_n, out_tvalid && (out_tuser != STATUS_SAMPLE),
    out_tlast && (out_tdata == '0), "error result not zero or not last")

  `IRSS_ASSERT_NOW(a_delta_nonzero, clk, rst_n, out_tvalid && (out_tuser == STATUS_SAMPLE),
    out_tdata[DELTA_LSB +: TICKS_W] != '0, "sample result with zero delta")

  `IRSS_ASSERT_NOW(a_ready_only_end, clk, rst_n, !in_tready, in_tlast,
    "non-final byte refused")

endmodule

bind imu_report_sample_sequencer_core irss_checker u_irss_checker (.*);

// ===== tb/sv/irss_sample_checker.sv =====
`timescale 1ns / 1ps
// Inertial report sequencer checker: predicts the sample and error beats and compares each one.
module irss_sample_checker
  import irss_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_tready,
  input  logic [7:0]          in_tdata,   // data_byte
  input  logic                in_tlast,
  input  logic                cfg_tvalid,
  input  logic                cfg_tready,
  input  logic [7:0]          cfg_tdata,  // sensor_report_id
  input  logic                out_tvalid,
  input  logic                out_tready,
  // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, sample_ticks, sample_seq, delta_ticks
  input  logic [OUT_W-1:0]    out_tdata,
  input  logic [STATUS_W-1:0] out_tuser,  // status
  input  logic                out_tlast,
  output int                  mismatches,
  output int                  pending
);

  localparam logic [7:0] REPORT_ID_RESET = 8'd32;
  localparam int         REPORT_LIMIT    = 10;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic signed [15:0]  accel_x;
    logic signed [15:0]  accel_y;
    logic signed [15:0]  accel_z;
    logic signed [15:0]  rate_x;
    logic signed [15:0]  rate_y;
    logic signed [15:0]  rate_z;
    logic [31:0]         sample_ticks;
    logic [7:0]          sample_seq;
    logic [31:0]         delta_ticks;
    logic                last;
  } imu_result_t;

  logic [7:0]  report_buf [0:REPORT_BYTES-1];
  int unsigned byte_cnt;
  logic [31:0] kept_stamp;
  logic [7:0]  report_id;
  imu_result_t due_results [$];
  int          fail_count = 0;
  int          beat_count = 0;

  function automatic logic stamp_is_newer(input logic [31:0] t, input logic [31:0] s);
    if (t == s) return 1'b0;
    if (t > s) return (t - s) < WRAP_WINDOW;
    return (s - t) > WRAP_WINDOW;
  endfunction

  function automatic logic [15:0] word_at(input int pos);
    return {report_buf[pos + 1], report_buf[pos]};
  endfunction

  function automatic logic [31:0] stamp_at(input int pos);
    return {report_buf[pos + 3], report_buf[pos + 2], report_buf[pos + 1], report_buf[pos]};
  endfunction

  function automatic void take_report_byte(input logic [7:0] b, input logic eor);
    int          len;
    int          oldest;
    int          k;
    int          base;
    int          n;
    logic [31:0] t;
    imu_result_t r;
    imu_result_t found [0:SAMPLE_COUNT-1];
    if (byte_cnt < REPORT_BYTES) report_buf[byte_cnt] = b;
    if (byte_cnt < COUNT_CAP) byte_cnt++;
    if (!eor) return;
    len = byte_cnt;
    byte_cnt = 0;
    if (report_buf[0] != report_id || len != REPORT_BYTES) begin
      r = '0;
      r.status = (report_buf[0] != report_id) ? STATUS_UNKNOWN_ID : STATUS_BAD_LENGTH;
      r.last = 1'b1;
      due_results.push_back(r);
      return;
    end
    // pick the oldest slot from the sequence numbers
    if (report_buf[17] == 8'(report_buf[34] + 8'd2)) begin
      oldest = 1;
    end else if (report_buf[34] == 8'(report_buf[51] + 8'd2)) begin
      oldest = 2;
    end else begin
      oldest = 0;
    end
    n = 0;
    for (k = 0; k < SAMPLE_COUNT; k++) begin
      base = 1 + ((oldest + k) % SAMPLE_COUNT) * SAMPLE_BYTES;
      t = stamp_at(base + 12);
      if (kept_stamp == '0) begin
        kept_stamp = t;
        continue;
      end
      if (!stamp_is_newer(t, kept_stamp)) continue;
      r = '0;
      r.status = STATUS_SAMPLE;
      r.accel_x = word_at(base);
      r.accel_y = word_at(base + 2);
      r.accel_z = word_at(base + 4);
      r.rate_x = word_at(base + 6);
      r.rate_y = word_at(base + 8);
      r.rate_z = word_at(base + 10);
      r.sample_ticks = t;
      r.sample_seq = report_buf[base + 16];
      r.delta_ticks = t - kept_stamp;
      kept_stamp = t;
      found[n] = r;
      n++;
    end
    for (k = 0; k < n; k++) begin
      if (k == n - 1) found[k].last = 1'b1;
      due_results.push_back(found[k]);
    end
  endfunction

  function automatic void check_beat();
    imu_result_t got;
    imu_result_t want;
    string       diffs;
    got.status = out_tuser;
    got.accel_x = out_tdata[15:0];
    got.accel_y = out_tdata[31:16];
    got.accel_z = out_tdata[47:32];
    got.rate_x = out_tdata[63:48];
    got.rate_y = out_tdata[79:64];
    got.rate_z = out_tdata[95:80];
    got.sample_ticks = out_tdata[127:96];
    got.sample_seq = out_tdata[135:128];
    got.delta_ticks = out_tdata[167:136];
    got.last = out_tlast;
    beat_count++;
    if (due_results.size() == 0) begin
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
        $display("result beat %0d arrived with none due: %h", beat_count, got);
      return;
    end
    want = due_results.pop_front();
    diffs = "";
    if (got.status !== want.status) diffs = {diffs, " status"};
    if (got.accel_x !== want.accel_x) diffs = {diffs, " accel_x"};
    if (got.accel_y !== want.accel_y) diffs = {diffs, " accel_y"};
    if (got.accel_z !== want.accel_z) diffs = {diffs, " accel_z"};
    if (got.rate_x !== want.rate_x) diffs = {diffs, " rate_x"};
    if (got.rate_y !== want.rate_y) diffs = {diffs, " rate_y"};
    if (got.rate_z !== want.rate_z) diffs = {diffs, " rate_z"};
    if (got.sample_ticks !== want.sample_ticks) diffs = {diffs, " sample_ticks"};
    if (got.sample_seq !== want.sample_seq) diffs = {diffs, " sample_seq"};
    if (got.delta_ticks !== want.delta_ticks) diffs = {diffs, " delta_ticks"};
    if (got.last !== want.last) diffs = {diffs, " last"};
    if (diffs != "") begin
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
        $display("result beat %0d differs in%s: expected %h, got %h",
                 beat_count, diffs, want, got);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REPORT_BYTES; i++) report_buf[i] = '0;
      byte_cnt = 0;
      kept_stamp = '0;
      report_id = REPORT_ID_RESET;
      due_results.delete();
    end else begin
      if (cfg_tvalid && cfg_tready) report_id = cfg_tdata;
      if (out_tvalid && out_tready) check_beat();
      if (in_tvalid && in_tready) take_report_byte(in_tdata, in_tlast);
    end
    pending <= due_results.size();
    mismatches <= fail_count;
  end

endmodule

// ===== tb/sv/imu_report_sample_sequencer_core_tb.sv =====
`timescale 1ns / 1ps
// Inertial report sequencer testbench top: drives report bytes and id writes, gives the verdict.
module imu_report_sample_sequencer_core_tb;
  import irss_pkg::*;

  localparam int         CYCLE_LIMIT     = 400000;
  localparam int         RX_HOLD_CYCLES  = 400;
  localparam int         SETTLE_CYCLES   = 12;
  localparam int         FRAME_MAX       = 64;
  localparam logic [7:0] REPORT_ID_RESET = 8'd32;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [7:0]          in_tdata   = '0;   // data_byte
  logic                in_tlast   = 1'b0;
  logic                cfg_tvalid = 1'b0;
  logic                cfg_tready;
  logic [7:0]          cfg_tdata  = '0;   // sensor_report_id
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, sample_ticks, sample_seq, delta_ticks
  logic [OUT_W-1:0]    out_tdata;
  logic [STATUS_W-1:0] out_tuser;         // status
  logic                out_tlast;

  int          mismatches;
  int          pending;
  int          results_seen = 0;
  int          cycle_count  = 0;
  logic        steady       = 1'b0;
  logic        rx_hold_req  = 1'b0;
  logic [7:0]  active_id    = REPORT_ID_RESET;
  logic [31:0] stamp_clock  = '0;
  logic [7:0]  frame [0:FRAME_MAX-1];
  int          frame_len;

  imu_report_sample_sequencer_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .cfg_tvalid (cfg_tvalid),
    .cfg_tready (cfg_tready),
    .cfg_tdata  (cfg_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  irss_sample_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .cfg_tvalid (cfg_tvalid),
    .cfg_tready (cfg_tready),
    .cfg_tdata  (cfg_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (rst_n && out_tvalid && out_tready) results_seen <= results_seen + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver: random backpressure, plus one long hold when requested
  initial begin : rx_side
    int   hold_left;
    logic hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req && !hold_seen) hold_left = RX_HOLD_CYCLES;
      hold_seen = rx_hold_req;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= steady || ($urandom_range(99) >= 20);
      end
    end
  end

  task automatic send_beat(input logic [7:0] d, input logic l);
    while (!steady && $urandom_range(99) < 20) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    in_tlast <= l;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_frame;
    int i;
    for (i = 0; i < frame_len; i++) send_beat(frame[i], i == frame_len - 1);
  endtask

  task automatic drain_results;
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_report_id(input logic [7:0] v);
    cfg_tvalid <= 1'b1;
    cfg_tdata <= v;
    @(posedge clk);
    while (!cfg_tready) @(posedge clk);
    cfg_tvalid <= 1'b0;
    active_id = v;
  endtask

  function automatic logic [31:0] next_stamp();
    int unsigned pick;
    logic [31:0] t;
    pick = $urandom_range(99);
    if (pick < 70) begin
      stamp_clock = stamp_clock + $urandom_range(1, 5000);
      t = stamp_clock;
    end else if (pick < 76) begin
      t = stamp_clock;
    end else if (pick < 82) begin
      t = stamp_clock - $urandom_range(1, 5000);
    end else if (pick < 85) begin
      t = stamp_clock + WRAP_WINDOW;
    end else if (pick < 88) begin
      stamp_clock = stamp_clock + WRAP_WINDOW - 1;
      t = stamp_clock;
    end else if (pick < 91) begin
      stamp_clock = stamp_clock - 32'h4000_0000;
      t = stamp_clock;
    end else if (pick < 94) begin
      stamp_clock = TICKS_ALL - $urandom_range(0, 3000);
      t = stamp_clock;
    end else if (pick < 97) begin
      t = '0;
    end else begin
      stamp_clock = $urandom;
      t = stamp_clock;
    end
    return t;
  endfunction

  function automatic sample_t make_sample(input logic [31:0] ticks, input logic [7:0] seq);
    logic [95:0] motion;
    int          k;
    motion = {$urandom, $urandom, $urandom};
    for (k = 0; k < 6; k++) begin
      case ($urandom_range(9))
        0: motion[16*k +: 16] = 16'h8000;
        1: motion[16*k +: 16] = 16'h7FFF;
        2: motion[16*k +: 16] = 16'hFFFF;
        3: motion[16*k +: 16] = 16'h0000;
        default: ;
      endcase
    end
    return {seq, ticks, motion};
  endfunction

  function automatic logic [3*SAMPLE_W-1:0] pack_slots(
    input logic [31:0] t0, input logic [31:0] t1, input logic [31:0] t2,
    input logic [7:0] q0, input logic [7:0] q1, input logic [7:0] q2,
    input logic [95:0] motion);
    return {q2, t2, motion, q1, t1, ~motion, q0, t0, motion};
  endfunction

  task automatic load_report(input logic [7:0] id, input logic [3*SAMPLE_W-1:0] slots);
    int k;
    int b;
    frame[0] = id;
    for (k = 0; k < SAMPLE_COUNT; k++)
      for (b = 0; b < SAMPLE_BYTES; b++)
        frame[1 + SAMPLE_BYTES*k + b] = slots[SAMPLE_W*k + 8*b +: 8];
    frame_len = REPORT_BYTES;
  endtask

  task automatic make_sample_report(input logic [7:0] id);
    int                    oldest;
    int                    k;
    int                    slot;
    logic [7:0]            seq0;
    logic [7:0]            sq;
    logic                  scrambled;
    logic [3*SAMPLE_W-1:0] slots;
    oldest = $urandom_range(2);
    seq0 = $urandom_range(255);
    scrambled = ($urandom_range(9) == 0);
    for (k = 0; k < SAMPLE_COUNT; k++) begin
      slot = (oldest + k) % SAMPLE_COUNT;
      sq = seq0 + k[7:0];
      if (scrambled) sq = $urandom_range(255);
      slots[SAMPLE_W*slot +: SAMPLE_W] = make_sample(next_stamp(), sq);
    end
    load_report(id, slots);
  endtask

  task automatic random_report;
    int unsigned pick;
    int          k;
    logic [7:0]  bad_id;
    pick = $urandom_range(99);
    bad_id = $urandom_range(1, 255);
    bad_id = bad_id ^ active_id;
    if (pick < 74) begin
      make_sample_report(active_id);
    end else if (pick < 80) begin
      make_sample_report(bad_id);
    end else if (pick < 86) begin
      make_sample_report(active_id);
      frame_len = $urandom_range(1, REPORT_BYTES - 1);
    end else if (pick < 91) begin
      make_sample_report(active_id);
      frame_len = $urandom_range(REPORT_BYTES + 1, FRAME_MAX);
      for (k = REPORT_BYTES; k < frame_len; k++) frame[k] = $urandom_range(255);
    end else if (pick < 95) begin
      make_sample_report(bad_id);
      frame_len = $urandom_range(1, REPORT_BYTES - 1);
    end else begin
      frame_len = $urandom_range(1, FRAME_MAX);
      for (k = 0; k < frame_len; k++) frame[k] = $urandom_range(255);
    end
    send_frame;
  endtask

  task automatic directed_reports;
    int k;
    // all stamps zero: stays unprimed
    load_report(REPORT_ID_RESET, pack_slots(0, 0, 0, 8'd0, 8'd1, 8'd2, '0));
    send_frame;
    // prime on the first stamp, emit the other two
    load_report(REPORT_ID_RESET, pack_slots(100, 200, 300, 8'd10, 8'd11, 8'd12, {6{16'h7FFF}}));
    send_frame;
    // oldest in slot 1 across seq wrap; window edge inside, then exactly at the window
    load_report(REPORT_ID_RESET,
                pack_slots(32'd301 + 2*WRAP_WINDOW - 1, 32'd301, 32'd301 + WRAP_WINDOW - 1,
                           8'd0, 8'd254, 8'd255, {6{16'h8000}}));
    send_frame;
    // oldest in slot 2: equal, older, then far back which counts as newer
    load_report(REPORT_ID_RESET,
                pack_slots(32'h4000_012A, 32'h0000_012B, 32'h4000_012B,
                           8'd8, 8'd9, 8'd7, {6{16'hFFFF}}));
    send_frame;
    load_report(REPORT_ID_RESET,
                pack_slots(32'h4000_0129, 32'h8000_0127, 32'hC000_0125,
                           8'd20, 8'd21, 8'd22, {$urandom, $urandom, $urandom}));
    send_frame;
    // stamps wrap past all ones
    load_report(REPORT_ID_RESET, pack_slots(32'hFFFF_FFF0, 32'h5, 32'h100,
                                            8'd23, 8'd24, 8'd25, '0));
    send_frame;
    stamp_clock = 32'h100;
    make_sample_report(8'd33);
    send_frame;
    frame[0] = 8'h00;
    frame_len = 1;
    send_frame;
    make_sample_report(REPORT_ID_RESET);
    frame_len = REPORT_BYTES - 1;
    send_frame;
    make_sample_report(REPORT_ID_RESET);
    for (k = REPORT_BYTES; k < 60; k++) frame[k] = 8'hFF;
    frame_len = 60;
    send_frame;
    frame[0] = REPORT_ID_RESET;
    frame_len = 1;
    send_frame;
  endtask

  initial begin : stimulus
    int k;
    int rand_start;
    int guard;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_reports();
    drain_results();

    // long output hold while the sender keeps pushing
    write_report_id(8'd0);
    rx_hold_req <= 1'b1;
    steady <= 1'b1;
    for (k = 0; k < 6; k++) begin
      make_sample_report(k[0] ? 8'd7 : active_id);
      send_frame;
    end
    steady <= 1'b0;
    drain_results();

    write_report_id(8'd255);
    steady <= 1'b1;
    for (k = 0; k < 4; k++) random_report();
    steady <= 1'b0;
    drain_results();

    write_report_id($urandom_range(255));
    for (k = 0; k < 4; k++) random_report();
    drain_results();

    write_report_id(REPORT_ID_RESET);
    rand_start = results_seen;
    guard = 0;
    while (results_seen - rand_start < 60 && guard < 120) begin
      random_report();
      guard++;
    end
    drain_results();

    if (mismatches == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/irss_pkg.sv
hw/rtl/irss_capture.sv
hw/rtl/imu_report_sample_sequencer_core.sv
hw/rtl/irss_checker.sv
tb/sv/irss_sample_checker.sv
tb/sv/imu_report_sample_sequencer_core_tb.sv
